// File: design/mrhd_pkg.sv
// ----------------------------------------------------------------------------
// mrhd_pkg
// Shared types and constants of the motor ramp and H-bridge drive block.
// ----------------------------------------------------------------------------
`default_nettype none

package mrhd_pkg;

  // Build-time sizing.
  localparam int MOTORS      = 2;
  localparam int PWM_PERIOD  = 1023;
  localparam int MirrorMotor = 1;
  localparam int MotorSelW   = (MOTORS > 1) ? $clog2(MOTORS) : 1;

  // Field widths.
  localparam int ReqW   = 2;
  localparam int IdxW   = 2;
  localparam int SpeedW = 11;
  localparam int CmpW   = 10;
  localparam int CfgW   = 10;
  localparam int WideW  = 13;

  // Configuration port geometry.
  localparam int NumRegs = 5;
  localparam int PaddrW  = $clog2(4 * NumRegs);
  localparam int PdataW  = 32;
  localparam int RegSelW = PaddrW - 2;

  // Compare value for a pin held constantly high.
  localparam logic [CmpW-1:0] PeriodCmp = CmpW'(PWM_PERIOD);

  // Register reset values.
  localparam logic [CfgW-1:0] SpeedLimitRst = CfgW'(1023);
  localparam logic [CfgW-1:0] DeadZoneRst   = CfgW'(400);
  localparam logic [CfgW-1:0] FastStepRst   = CfgW'(64);
  localparam logic [CfgW-1:0] SlowStepRst   = CfgW'(16);
  localparam logic [CfgW-1:0] DecelStepRst  = CfgW'(64);

  typedef enum logic [ReqW-1:0] {
    ReqRamp  = 2'd0,
    ReqSet   = 2'd1,
    ReqStop  = 2'd2,
    ReqBrake = 2'd3
  } req_type_e;

  typedef enum logic [RegSelW-1:0] {
    RegSpeedLimit = 3'd0,
    RegDeadZone   = 3'd1,
    RegFastStep   = 3'd2,
    RegSlowStep   = 3'd3,
    RegDecelStep  = 3'd4
  } reg_idx_e;

  typedef struct packed {
    logic [CfgW-1:0] speed_limit;
    logic [CfgW-1:0] dead_zone;
    logic [CfgW-1:0] fast_step;
    logic [CfgW-1:0] slow_step;
    logic [CfgW-1:0] decel_step;
  } cfg_t;

endpackage

`default_nettype wire

// File: design/mrhd_req_if.sv
// ----------------------------------------------------------------------------
// mrhd_req_if
// Request channel: valid/ready handshake with one drive request per word.
// ----------------------------------------------------------------------------
`default_nettype none

interface mrhd_req_if;

  logic                          valid;
  logic                          ready;
  logic [mrhd_pkg::ReqW-1:0]     req_type;
  logic [mrhd_pkg::IdxW-1:0]     motor_index;
  logic signed [mrhd_pkg::SpeedW-1:0] target_speed;

  modport source (output valid, output req_type, output motor_index,
                  output target_speed, input ready);
  modport sink   (input valid, input req_type, input motor_index,
                  input target_speed, output ready);

endinterface

`default_nettype wire

// File: design/mrhd_rsp_if.sv
// ----------------------------------------------------------------------------
// mrhd_rsp_if
// Result channel: valid/ready handshake with one drive result per word.
// ----------------------------------------------------------------------------
`default_nettype none

interface mrhd_rsp_if;

  logic                               valid;
  logic                               ready;
  logic [mrhd_pkg::IdxW-1:0]          motor_echo;
  logic [mrhd_pkg::CmpW-1:0]          fwd_compare;
  logic [mrhd_pkg::CmpW-1:0]          rev_compare;
  logic signed [mrhd_pkg::SpeedW-1:0] actual_speed;
  logic                               status;

  modport source (output valid, output motor_echo, output fwd_compare,
                  output rev_compare, output actual_speed, output status,
                  input ready);
  modport sink   (input valid, input motor_echo, input fwd_compare,
                  input rev_compare, input actual_speed, input status,
                  output ready);

endinterface

`default_nettype wire

// File: design/motor_ramp_hbridge_drive_top.sv
// ----------------------------------------------------------------------------
// motor_ramp_hbridge_drive_top
// Per-motor speed ramp with H-bridge forward/reverse compare generation.
// ----------------------------------------------------------------------------
// Each request word names a motor and a signed target speed. The block
// accepts one request per clock while the result side is not stalled and
// returns exactly one result word per request, in order; each request passes
// through the input register and then the result register. The per-motor
// speed is read, updated and written back in the single cycle in which a
// request moves from the input register to the result register, so
// back-to-back requests to the same motor always see each other's updates.
// Motor 1 has mirrored wiring and its direction is inverted internally. A
// motor index at or above the motor count returns status 1 and changes
// nothing. Configuration registers (speed limit, dead zone, fast, slow and
// decel steps) sit at byte addresses 0, 4, 8, 12 and 16 and should only be
// written while no request is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module motor_ramp_hbridge_drive_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mrhd_pkg::PaddrW-1:0]   paddr,
  input  logic [mrhd_pkg::PdataW-1:0]   pwdata,
  output logic [mrhd_pkg::PdataW-1:0]   prdata,
  output logic                          pready,
  mrhd_req_if.sink                      req_i,
  mrhd_rsp_if.source                    rsp_o
);

  import mrhd_pkg::*;

  // Configuration registers.
  cfg_t cfg_q, cfg_d;

  // Input register.
  logic                     s1_valid_q, s1_valid_d;
  req_type_e                s1_req_q;
  logic [IdxW-1:0]          s1_idx_q;
  logic signed [SpeedW-1:0] s1_tgt_q;

  // Result register.
  logic                     out_valid_q, out_valid_d;
  logic [IdxW-1:0]          out_echo_q;
  logic [CmpW-1:0]          out_fwd_q, out_fwd_d;
  logic [CmpW-1:0]          out_rev_q, out_rev_d;
  logic signed [SpeedW-1:0] out_act_q, out_act_d;
  logic                     out_status_q, out_status_d;

  // Stored speed of each motor, in physical direction.
  logic signed [SpeedW-1:0] speed_q [MOTORS];

  // Handshake.
  logic out_free, s1_move, in_fire, cfg_wr;

  // Datapath.
  logic                     motor_ok, mirror, accel, brake;
  logic [MotorSelW-1:0]     sel;
  logic signed [WideW-1:0]  tgt_raw, tgt_dir, tgt_cl, lim_s, act_s;
  logic signed [WideW-1:0]  diff, step_s, new_sp, phys_neg;
  logic [WideW-1:0]         mag_tgt, mag_act, mag_new;
  logic [CfgW-1:0]          step;
  logic [CmpW-1:0]          cmp;
  logic signed [SpeedW-1:0] new_speed;

  // Configuration write and readback.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_wr) begin
      unique case (reg_idx_e'(paddr[PaddrW-1:2]))
        RegSpeedLimit: cfg_d.speed_limit = pwdata[CfgW-1:0];
        RegDeadZone:   cfg_d.dead_zone   = pwdata[CfgW-1:0];
        RegFastStep:   cfg_d.fast_step   = pwdata[CfgW-1:0];
        RegSlowStep:   cfg_d.slow_step   = pwdata[CfgW-1:0];
        RegDecelStep:  cfg_d.decel_step  = pwdata[CfgW-1:0];
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx_e'(paddr[PaddrW-1:2]))
      RegSpeedLimit: prdata = PdataW'(cfg_q.speed_limit);
      RegDeadZone:   prdata = PdataW'(cfg_q.dead_zone);
      RegFastStep:   prdata = PdataW'(cfg_q.fast_step);
      RegSlowStep:   prdata = PdataW'(cfg_q.slow_step);
      RegDecelStep:  prdata = PdataW'(cfg_q.decel_step);
      default:       prdata = '0;
    endcase
  end

  // Two-register pipeline; the input register advances when the result
  // register is empty or being taken.
  assign out_free    = !out_valid_q || rsp_o.ready;
  assign s1_move     = s1_valid_q && out_free;
  assign req_i.ready = !s1_valid_q || s1_move;
  assign in_fire     = req_i.valid && req_i.ready;
  assign s1_valid_d  = in_fire || (s1_valid_q && !s1_move);
  assign out_valid_d = s1_move || (out_valid_q && !rsp_o.ready);

  // Motor selection and direction correction.
  assign motor_ok = int'(s1_idx_q) < MOTORS;
  assign mirror   = int'(s1_idx_q) == MirrorMotor;
  assign sel      = s1_idx_q[MotorSelW-1:0];

  // Target clamp to the speed limit.
  always_comb begin
    tgt_raw = WideW'(s1_tgt_q);
    tgt_dir = mirror ? -tgt_raw : tgt_raw;
    lim_s   = signed'(WideW'(cfg_q.speed_limit));
    if (tgt_dir > lim_s) begin
      tgt_cl = lim_s;
    end else if (tgt_dir < -lim_s) begin
      tgt_cl = -lim_s;
    end else begin
      tgt_cl = tgt_dir;
    end
  end

  // Ramp step choice and the new speed.
  always_comb begin
    act_s   = WideW'(speed_q[sel]);
    mag_tgt = unsigned'((tgt_cl < 0) ? -tgt_cl : tgt_cl);
    mag_act = unsigned'((act_s < 0) ? -act_s : act_s);
    accel   = mag_tgt > mag_act;
    if (accel) begin
      step = (mag_act < WideW'(cfg_q.dead_zone)) ? cfg_q.fast_step : cfg_q.slow_step;
    end else begin
      step = cfg_q.decel_step;
    end
    step_s = signed'(WideW'(step));
    diff   = tgt_cl - act_s;
    if (diff > step_s) begin
      diff = step_s;
    end else if (diff < -step_s) begin
      diff = -step_s;
    end
    brake = 1'b0;
    unique case (s1_req_q)
      ReqRamp:  new_sp = act_s + diff;
      ReqSet:   new_sp = tgt_cl;
      ReqStop:  new_sp = '0;
      ReqBrake: begin
        new_sp = '0;
        brake  = 1'b1;
      end
      default:  new_sp = '0;
    endcase
    new_speed = SpeedW'(new_sp);
  end

  // Compare values and result fields.
  always_comb begin
    mag_new  = unsigned'((new_sp < 0) ? -new_sp : new_sp);
    cmp      = (32'(mag_new) > PWM_PERIOD) ? PeriodCmp : CmpW'(mag_new);
    phys_neg = -new_sp;
    out_status_d = !motor_ok;
    if (!motor_ok) begin
      out_fwd_d = '0;
      out_rev_d = '0;
      out_act_d = '0;
    end else begin
      if (brake) begin
        out_fwd_d = PeriodCmp;
        out_rev_d = PeriodCmp;
      end else if (new_sp > 0) begin
        out_fwd_d = cmp;
        out_rev_d = '0;
      end else if (new_sp < 0) begin
        out_fwd_d = '0;
        out_rev_d = cmp;
      end else begin
        out_fwd_d = '0;
        out_rev_d = '0;
      end
      out_act_d = mirror ? SpeedW'(phys_neg) : new_speed;
    end
  end

  // Control state and stored speeds.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.speed_limit <= SpeedLimitRst;
      cfg_q.dead_zone   <= DeadZoneRst;
      cfg_q.fast_step   <= FastStepRst;
      cfg_q.slow_step   <= SlowStepRst;
      cfg_q.decel_step  <= DecelStepRst;
      s1_valid_q        <= 1'b0;
      out_valid_q       <= 1'b0;
      for (int k = 0; k < MOTORS; k++) begin
        speed_q[k] <= '0;
      end
    end else begin
      cfg_q       <= cfg_d;
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (s1_move && motor_ok) begin
        speed_q[sel] <= new_speed;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_req_q <= req_type_e'(req_i.req_type);
      s1_idx_q <= req_i.motor_index;
      s1_tgt_q <= req_i.target_speed;
    end
    if (s1_move) begin
      out_echo_q   <= s1_idx_q;
      out_fwd_q    <= out_fwd_d;
      out_rev_q    <= out_rev_d;
      out_act_q    <= out_act_d;
      out_status_q <= out_status_d;
    end
  end

  // Result channel.
  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.motor_echo   = out_echo_q;
  assign rsp_o.fwd_compare  = out_fwd_q;
  assign rsp_o.rev_compare  = out_rev_q;
  assign rsp_o.actual_speed = out_act_q;
  assign rsp_o.status       = out_status_q;

endmodule

`default_nettype wire

// File: bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the motor ramp and H-bridge drive block. Request
// words go in on the request channel, and a scoreboard predicts the result
// word for each accepted request. It keeps its own copy of the per-motor
// speeds and of the configuration registers. Each result word is checked
// field by field against the oldest prediction. Directed words cover the
// extremes and corner cases, and random phases then run under several
// register settings and several idling patterns.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mrhd_pkg::*;

  localparam int CycleLimit  = 300000;
  localparam int DrainCycles = 10;
  localparam int PhaseWords  = 200;
  localparam int NumPhases   = 7;

  // One result word as the block should return it.
  typedef struct packed {
    logic [IdxW-1:0]          motor;
    logic [CmpW-1:0]          fwd;
    logic [CmpW-1:0]          rev;
    logic signed [SpeedW-1:0] speed;
    logic                     status;
  } drive_result_t;

  // Predicts the drive results and checks the words that come back.
  class drive_scoreboard;
    cfg_t                     cfg;
    logic signed [SpeedW-1:0] motor_speed [MOTORS];
    drive_result_t            pending_results [$];
    int                       mismatches;

    function new();
      cfg = '{speed_limit: SpeedLimitRst, dead_zone: DeadZoneRst,
              fast_step: FastStepRst, slow_step: SlowStepRst,
              decel_step: DecelStepRst};
      foreach (motor_speed[k]) motor_speed[k] = '0;
      mismatches = 0;
    endfunction

    function int magnitude(int v);
      return (v < 0) ? -v : v;
    endfunction

    function logic [CmpW-1:0] to_compare(int m);
      return CmpW'((m > PWM_PERIOD) ? PWM_PERIOD : m);
    endfunction

    // Formats the fields of one result word for a report line.
    function string fmt_result(drive_result_t r);
      return $sformatf("motor=%0d fwd=%0d rev=%0d speed=%0d status=%0d",
                       r.motor, r.fwd, r.rev, $signed(r.speed), r.status);
    endfunction

    // Register writes; indexes past the last register are ignored.
    function void write_config(logic [RegSelW-1:0] sel, logic [PdataW-1:0] data);
      case (sel)
        RegSpeedLimit: cfg.speed_limit = data[CfgW-1:0];
        RegDeadZone:   cfg.dead_zone   = data[CfgW-1:0];
        RegFastStep:   cfg.fast_step   = data[CfgW-1:0];
        RegSlowStep:   cfg.slow_step   = data[CfgW-1:0];
        RegDecelStep:  cfg.decel_step  = data[CfgW-1:0];
        default: ;
      endcase
    endfunction

    // Works out the result of one accepted request and updates the speeds.
    function void note_request(req_type_e kind, logic [IdxW-1:0] motor,
                               logic signed [SpeedW-1:0] target);
      drive_result_t        r;
      logic [MotorSelW-1:0] slot;
      int goal, cur, delta, stride, next_speed, lim, logical;
      r = '0;
      r.motor = motor;
      if (motor >= MOTORS) begin
        r.status = 1'b1;
        pending_results.push_back(r);
        return;
      end
      slot = motor[MotorSelW-1:0];
      lim  = int'(cfg.speed_limit);
      goal = int'(target);
      if (motor == MirrorMotor) goal = -goal;
      if (goal > lim) goal = lim;
      if (goal < -lim) goal = -lim;

      case (kind)
        ReqRamp: begin
          cur   = int'(motor_speed[slot]);
          delta = goal - cur;
          // Accelerating uses the fast or slow step, anything else the decel step.
          if (magnitude(goal) > magnitude(cur))
            stride = (magnitude(cur) < int'(cfg.dead_zone)) ? int'(cfg.fast_step)
                                                            : int'(cfg.slow_step);
          else
            stride = int'(cfg.decel_step);
          if (delta > stride) delta = stride;
          if (delta < -stride) delta = -stride;
          next_speed = cur + delta;
        end
        ReqSet:  next_speed = goal;
        default: next_speed = 0;
      endcase
      motor_speed[slot] = SpeedW'(next_speed);

      if (kind == ReqBrake) begin
        r.fwd = PeriodCmp;
        r.rev = PeriodCmp;
      end else if (next_speed > 0) begin
        r.fwd = to_compare(next_speed);
      end else if (next_speed < 0) begin
        r.rev = to_compare(-next_speed);
      end
      logical = (motor == MirrorMotor) ? -next_speed : next_speed;
      r.speed = SpeedW'(logical);
      pending_results.push_back(r);
    endfunction

    // Compares one accepted result word with the oldest prediction.
    function void check_result(drive_result_t got);
      drive_result_t want;
      bit bad;
      if (pending_results.size() == 0) begin
        mismatches++;
        $display("%0t: result word with none expected: expected nothing, got %s",
                 $time, fmt_result(got));
        return;
      end
      want = pending_results.pop_front();
      bad  = (got.motor !== want.motor) || (got.fwd !== want.fwd) ||
             (got.rev !== want.rev) || (got.speed !== want.speed) ||
             (got.status !== want.status);
      if (bad) begin
        mismatches++;
        $display("%0t: result mismatch: expected %s, got %s",
                 $time, fmt_result(want), fmt_result(got));
      end
    endfunction
  endclass

  logic              clk;
  logic              rst_n;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [PaddrW-1:0] paddr;
  logic [PdataW-1:0] pwdata;
  logic [PdataW-1:0] prdata;
  logic              pready;

  mrhd_req_if req_ch ();
  mrhd_rsp_if rsp_ch ();

  motor_ramp_hbridge_drive_top u_top (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .req_i   (req_ch),
    .rsp_o   (rsp_ch)
  );

  drive_scoreboard          sb = new();
  int                       send_idle_pct;
  int                       recv_idle_pct;
  int                       cycle_count;
  logic signed [SpeedW-1:0] held_goal [4] = '{default: '0};

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: a run that hangs is a failure.
  initial begin
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Mismatches found");
    $finish;
  end

  // Result side: take the word if accepted, then decide on ready for the next edge.
  initial begin
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && rsp_ch.valid && rsp_ch.ready)
        sb.check_result('{motor: rsp_ch.motor_echo, fwd: rsp_ch.fwd_compare,
                          rev: rsp_ch.rev_compare, speed: rsp_ch.actual_speed,
                          status: rsp_ch.status});
      rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Offers one request word, with random idle cycles ahead of it.
  task automatic send_word(req_type_e kind, logic [IdxW-1:0] motor,
                           logic signed [SpeedW-1:0] target);
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid        <= 1'b1;
    req_ch.req_type     <= kind;
    req_ch.motor_index  <= motor;
    req_ch.target_speed <= target;
    do @(posedge clk); while (!req_ch.ready);
    sb.note_request(kind, motor, target);
  endtask

  // One APB write: setup cycle, then access until pready.
  task automatic write_reg(logic [RegSelW-1:0] sel, logic [CfgW-1:0] value);
    logic [PdataW-1:0] data;
    data           = $urandom;
    data[CfgW-1:0] = value;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {sel, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.write_config(sel, data);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_all(int lim, int dz, int fast, int slow, int decel);
    write_reg(RegSpeedLimit, CfgW'(lim));
    write_reg(RegDeadZone, CfgW'(dz));
    write_reg(RegFastStep, CfgW'(fast));
    write_reg(RegSlowStep, CfgW'(slow));
    write_reg(RegDecelStep, CfgW'(decel));
  endtask

  task automatic wait_drained();
    while (sb.pending_results.size() != 0) @(posedge clk);
  endtask

  // Register settings per phase; the second one lowers the limit under high speeds.
  task automatic program_phase(int phase);
    int k;
    case (phase)
      0: write_all(1023, 1023, 1023, 1023, 1023);
      1: write_all(150, 60, 20, 5, 10);
      2: write_all(0, 0, 0, 0, 0);
      3: begin
        write_all($urandom_range(1023), $urandom_range(1023), $urandom_range(1023),
                  $urandom_range(1023), $urandom_range(1023));
        // Writes past the last register must leave everything unchanged.
        for (k = NumRegs; k < (1 << RegSelW); k++)
          write_reg(RegSelW'(k), CfgW'($urandom_range(1023)));
      end
      default: write_all($urandom_range(1023), $urandom_range(1023), $urandom_range(1, 96),
                         $urandom_range(1, 48), $urandom_range(1, 96));
    endcase
  endtask

  // Mostly values that ramp somewhere, with the edges of the range mixed in.
  function automatic logic signed [SpeedW-1:0] pick_target();
    int lim;
    lim = int'(sb.cfg.speed_limit);
    case ($urandom_range(11))
      0:       return SpeedW'(-1024);
      1:       return SpeedW'(1023);
      2:       return '0;
      3:       return SpeedW'(lim);
      4:       return SpeedW'(-lim);
      5:       return SpeedW'($urandom_range(3) - 1);
      default: return SpeedW'($urandom_range(2047));
    endcase
  endfunction

  // Random words: per-motor goals held over several requests so ramps get far.
  task automatic run_random(int count);
    int                       n;
    int                       roll;
    logic [IdxW-1:0]          motor;
    req_type_e                kind;
    logic signed [SpeedW-1:0] target;
    for (n = 0; n < count; n++) begin
      if ($urandom_range(99) < 8)
        motor = IdxW'($urandom_range(3, MOTORS));
      else
        motor = IdxW'($urandom_range(MOTORS - 1));
      roll = $urandom_range(99);
      if (roll < 60) kind = ReqRamp;
      else if (roll < 75) kind = ReqSet;
      else if (roll < 90) kind = ReqStop;
      else kind = ReqBrake;
      if ($urandom_range(99) < 20) held_goal[motor] = pick_target();
      target = (kind == ReqStop || kind == ReqBrake) ? pick_target() : held_goal[motor];
      send_word(kind, motor, target);
    end
    req_ch.valid <= 1'b0;
  endtask

  initial begin
    int phase;
    send_idle_pct       = 30;
    recv_idle_pct       = 45;
    rst_n               <= 1'b0;
    psel                <= 1'b0;
    penable             <= 1'b0;
    pwrite              <= 1'b0;
    paddr               <= '0;
    pwdata              <= '0;
    req_ch.valid        <= 1'b0;
    req_ch.req_type     <= ReqRamp;
    req_ch.motor_index  <= '0;
    req_ch.target_speed <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed words at the reset settings.
    send_word(ReqSet, 0, 1023);
    send_word(ReqSet, 0, -1024);    // most negative pattern gets clamped
    send_word(ReqSet, 1, -1024);    // mirrored motor: negation then clamp
    send_word(ReqSet, 1, 1023);
    send_word(ReqRamp, 0, 1023);    // reversal uses the decel step
    send_word(ReqRamp, 1, -1024);
    send_word(ReqStop, 0, 500);
    send_word(ReqRamp, 0, 1023);    // from rest: fast step
    send_word(ReqRamp, 0, -1);
    send_word(ReqSet, 0, 399);
    send_word(ReqRamp, 0, 1023);    // just under the dead zone: fast step
    send_word(ReqRamp, 0, 1023);    // above it: slow step
    send_word(ReqSet, 1, -400);
    send_word(ReqRamp, 1, -1023);   // exactly at the dead zone: slow step
    send_word(ReqBrake, 1, 1023);
    send_word(ReqRamp, 1, 0);       // zero speed leaves both compares low
    send_word(ReqSet, 0, 1);
    send_word(ReqSet, 0, -1);
    send_word(ReqSet, 0, 0);
    send_word(ReqSet, 2, 700);      // invalid motors change nothing
    send_word(ReqBrake, 3, -1024);
    send_word(ReqRamp, 2, 1023);
    send_word(ReqStop, 1, -1);
    send_word(ReqBrake, 0, 0);
    req_ch.valid <= 1'b0;

    for (phase = 0; phase < NumPhases; phase++) begin
      wait_drained();
      program_phase(phase);
      if (phase >= 5) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end else if (phase >= 3) begin
        send_idle_pct = 45;
        recv_idle_pct = 30;
      end
      run_random(PhaseWords);
    end

    wait_drained();
    repeat (DrainCycles) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending_results.size() == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
